/* rtl/mts_pkg.sv */
package mts_pkg;

    // sizes
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int COORD_W   = 16;
    localparam int ID_W      = 16;
    localparam int SCALE_W   = 16;
    localparam int IDX_W     = 3;
    localparam int PROD_W    = COORD_W + SCALE_W;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    // event codes on the command port
    typedef enum logic [1:0] {
        FN_TICK = 2'd0,
        FN_DOWN = 2'd1,
        FN_MOVE = 2'd2,
        FN_UP   = 2'd3
    } func_t;

    // per-slot phase
    typedef enum logic [1:0] {
        PH_EMPTY = 2'd0,
        PH_DOWN  = 2'd1,
        PH_MOVE  = 2'd2,
        PH_UP    = 2'd3
    } phase_t;

    // report codes
    typedef enum logic [1:0] {
        KIND_PRESSED  = 2'd0,
        KIND_MOVED    = 2'd1,
        KIND_RELEASED = 2'd2
    } kind_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_APPLY,
        ST_REPORT
    } state_t;

    typedef struct packed {
        func_t                      func;
        logic signed [COORD_W-1:0]  x_raw;
        logic signed [COORD_W-1:0]  y_raw;
        logic [ID_W-1:0]            contact_id;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]           slot_index;
        kind_t                      report_kind;
        logic [ID_W-1:0]            report_id;
        logic signed [COORD_W-1:0]  report_x;
        logic signed [COORD_W-1:0]  report_y;
        logic                       last;
    } result_t;

    // contents of one slot
    typedef struct packed {
        phase_t                     phase;
        logic [ID_W-1:0]            contact;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } slot_t;

    // control broadcast to every cell
    typedef struct packed {
        logic                       apply;
        logic                       shift;
        logic                       any_match;
        func_t                      func;
        logic [ID_W-1:0]            id;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } cell_ctl_t;

    // slot state after its report: released slots free, pressed slots move
    function automatic slot_t retire_slot(input slot_t s);
        slot_t r;
        r = s;
        if (s.phase == PH_UP) begin
            r = '0;
        end else if (s.phase == PH_DOWN) begin
            r.phase = PH_MOVE;
        end
        return r;
    endfunction

    // report code for an active phase
    function automatic kind_t kind_of(input phase_t p);
        kind_t k;
        unique case (p)
            PH_DOWN: k = KIND_PRESSED;
            PH_MOVE: k = KIND_MOVED;
            PH_UP:   k = KIND_RELEASED;
            default: k = KIND_PRESSED;
        endcase
        return k;
    endfunction

endpackage

/* rtl/mts_scaler.sv */
module mts_scaler (
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [mts_pkg::COORD_W-1:0] raw,
    input  logic [mts_pkg::SCALE_W-1:0]        scale,
    output logic signed [mts_pkg::COORD_W-1:0] scaled
);
    import mts_pkg::*;

    logic                     neg;
    logic [COORD_W-1:0]       mag;
    logic                     neg_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [PROD_W-9:0]        shifted;

    // magnitude of the raw coordinate, most negative value gives 0x8000
    assign neg = raw[COORD_W-1];
    assign mag = neg ? COORD_W'(-raw) : COORD_W'(raw);

    // registered product
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg  <= neg;
            prod_reg <= PROD_W'(mag) * PROD_W'(scale);
        end
    end

    assign shifted = prod_reg[PROD_W-1:8];

    // truncate toward zero and saturate to signed 16 bits
    always_comb
    begin
        if (neg_reg)
        begin
            if (shifted >= (PROD_W-8)'(32768))
                scaled = 16'sh8000;
            else
                scaled = COORD_W'(-shifted[COORD_W-1:0]);
        end
        else
        begin
            if (shifted > (PROD_W-8)'(32767))
                scaled = 16'sh7FFF;
            else
                scaled = shifted[COORD_W-1:0];
        end
    end

endmodule

/* rtl/mts_cell.sv */
module mts_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mts_pkg::cell_ctl_t   ctl,
    input  logic                 match_in,
    input  logic                 free_in,
    input  mts_pkg::slot_t       shift_data,
    output logic                 match_out,
    output logic                 free_out,
    output mts_pkg::slot_t       slot
);
    import mts_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;
    logic  empty;
    logic  hit;
    logic  take;
    logic  claim;

    // matching: first active slot with this id, first empty slot for a new down
    assign empty     = (slot_reg.phase == PH_EMPTY);
    assign hit       = !empty && (slot_reg.contact == ctl.id);
    assign take      = hit && !match_in;
    assign claim     = (ctl.func == FN_DOWN) && !ctl.any_match && empty && !free_in;
    assign match_out = match_in | hit;
    assign free_out  = free_in | empty;

    // next slot contents
    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.shift)
        begin
            slot_next = shift_data;
        end
        else if (ctl.apply)
        begin
            if (take && ((ctl.func == FN_MOVE) || (ctl.func == FN_UP)))
            begin
                slot_next.phase = phase_t'(ctl.func);
                slot_next.x     = ctl.x;
                slot_next.y     = ctl.y;
            end
            else if (claim)
            begin
                slot_next.phase   = PH_DOWN;
                slot_next.contact = ctl.id;
                slot_next.x       = ctl.x;
                slot_next.y       = ctl.y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

/* rtl/multitouch_slot_tracker.sv */
// a command transfer is followed by scaling (ST_MUL) and slot update (ST_APPLY),
// then ST_REPORT, in which the cell ring rotates once past the report port;
// each report strobe is registered and comes in the cycle after its ring step
// busy holds off a new command until the ring turn ends and the sequencer is idle again
// each active slot gives one report strobe; the receiver cannot stall, results are not held
// reset: all slots empty with zero id and coordinates, scale 1.0 (256)
module multitouch_slot_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  mts_pkg::cmd_t                cmd,
    output logic                         busy,
    input  logic                         cfg_we,
    input  logic [mts_pkg::SCALE_W-1:0]  cfg_wdata,
    output logic                         result_valid,
    output mts_pkg::result_t             result
);
    import mts_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [SLOT_W-1:0]     cnt_reg;
    logic [SLOT_W-1:0]     cnt_next;
    logic [SCALE_W-1:0]    scale_reg;
    cmd_t                  cmd_reg;
    result_t               result_reg;
    result_t               result_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  accept;
    logic                  mul_load;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    cell_ctl_t             ctl;
    logic [NUM_SLOTS:0]    match_chain;
    logic [NUM_SLOTS:0]    free_chain;
    slot_t                 slots [NUM_SLOTS];
    slot_t                 wrap_data;
    logic                  more_active;
    logic                  cnt_done;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign mul_load = (state_reg == ST_MUL);
    assign cnt_done = (cnt_reg == SLOT_W'(NUM_SLOTS - 1));

    // scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg_we)
            scale_reg <= cfg_wdata;
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
    end

    // coordinate scaling
    mts_scaler u_scale_x (
        .clk    (clk),
        .load   (mul_load),
        .raw    (cmd_reg.x_raw),
        .scale  (scale_reg),
        .scaled (sx)
    );

    mts_scaler u_scale_y (
        .clk    (clk),
        .load   (mul_load),
        .raw    (cmd_reg.y_raw),
        .scale  (scale_reg),
        .scaled (sy)
    );

    // cell control broadcast
    always_comb
    begin
        ctl.apply     = (state_reg == ST_APPLY) && (cmd_reg.func != FN_TICK);
        ctl.shift     = (state_reg == ST_REPORT);
        ctl.any_match = match_chain[NUM_SLOTS];
        ctl.func      = cmd_reg.func;
        ctl.id        = cmd_reg.contact_id;
        ctl.x         = sx;
        ctl.y         = sy;
    end

    assign match_chain[0] = 1'b0;
    assign free_chain[0]  = 1'b0;
    assign wrap_data      = retire_slot(slots[0]);

    // ring of slot cells, cell 0 faces the report port
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        slot_t neighbor;
        if (i == NUM_SLOTS - 1)
        begin : g_wrap
            assign neighbor = wrap_data;
        end
        else
        begin : g_link
            assign neighbor = slots[i+1];
        end

        mts_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .match_in   (match_chain[i]),
            .free_in    (free_chain[i]),
            .shift_data (neighbor),
            .match_out  (match_chain[i+1]),
            .free_out   (free_chain[i+1]),
            .slot       (slots[i])
        );
    end

    // any unreported active slot still ahead in the ring
    always_comb
    begin
        more_active = 1'b0;
        for (int j = 1; j < NUM_SLOTS; j++)
        begin
            if ((slots[j].phase != PH_EMPTY) &&
                ((SLOT_W+1)'(j) + (SLOT_W+1)'(cnt_reg) <= (SLOT_W+1)'(NUM_SLOTS - 1)))
                more_active = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        valid_next  = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cnt_next   = '0;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (slots[0].phase != PH_EMPTY)
                begin
                    valid_next              = 1'b1;
                    result_next.slot_index  = IDX_W'(cnt_reg);
                    result_next.report_kind = kind_of(slots[0].phase);
                    result_next.report_id   = slots[0].contact;
                    result_next.report_x    = slots[0].x;
                    result_next.report_y    = slots[0].y;
                    result_next.last        = !more_active;
                end
                if (cnt_done)
                    state_next = ST_IDLE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    // a report strobe only follows a ring step
    a_strobe_from_ring: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_REPORT))
        else $error("report strobe without ring step");

    // the final report of a command is not followed by another at once
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("report right after final report");

    // a command transfer makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after command transfer");

    // the ring makes exactly one turn before going idle
    a_full_turn: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_REPORT) && (state_next == ST_IDLE)) |-> cnt_done)
        else $error("ring left before a full turn");

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int SETTLE      = NUM_SLOTS + 4;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 29;
    localparam int NUM_PHASES  = 5;
    localparam int POOL_SIZE   = 10;

    // one directed step: the command and, where obvious, its single report
    typedef struct packed {
        cmd_t    c;
        logic    hand_ok;
        result_t hand;
    } step_row_t;

    localparam result_t NO_HAND = '0;

    localparam step_row_t TOUCH_SCRIPT [26] = '{
        '{'{FN_TICK, 16'h8000, 16'h7FFF, 16'hFFFF}, 1'b0, NO_HAND},
        '{'{FN_DOWN, 16'h7FFF, 16'h8000, 16'h0000}, 1'b1,
          '{3'd0, KIND_PRESSED, 16'h0000, 16'h7FFF, 16'h8000, 1'b1}},
        '{'{FN_MOVE, 16'h0100, 16'h0200, 16'h1234}, 1'b1,
          '{3'd0, KIND_MOVED, 16'h0000, 16'h7FFF, 16'h8000, 1'b1}},
        '{'{FN_DOWN, 16'h0005, 16'h0006, 16'h0000}, 1'b1,
          '{3'd0, KIND_MOVED, 16'h0000, 16'h7FFF, 16'h8000, 1'b1}},
        '{'{FN_MOVE, 16'hFFFF, 16'h0001, 16'h0000}, 1'b1,
          '{3'd0, KIND_MOVED, 16'h0000, 16'hFFFF, 16'h0001, 1'b1}},
        '{'{FN_DOWN, 16'h1234, 16'hEDCC, 16'hFFFF}, 1'b0, NO_HAND},
        '{'{FN_DOWN, 16'h0400, 16'h0800, 16'h0001}, 1'b0, NO_HAND},
        '{'{FN_DOWN, 16'h7000, 16'h9000, 16'h0002}, 1'b0, NO_HAND},
        '{'{FN_DOWN, 16'h0055, 16'hFFAA, 16'h0003}, 1'b0, NO_HAND},
        '{'{FN_DOWN, 16'h4000, 16'hC000, 16'h0004}, 1'b0, NO_HAND},
        '{'{FN_DOWN, 16'h0001, 16'h7FFE, 16'h0005}, 1'b0, NO_HAND},
        '{'{FN_DOWN, 16'h8001, 16'h0000, 16'h0006}, 1'b0, NO_HAND},
        '{'{FN_DOWN, 16'h0101, 16'h0202, 16'hABCD}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_HAND},
        '{'{FN_TICK, 16'h5A5A, 16'hA5A5, 16'h0004}, 1'b0, NO_HAND},
        '{'{FN_DOWN, 16'h0010, 16'h0020, 16'h5555}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h8000, 16'h7FFF, 16'h5555}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h1111, 16'h2222, 16'h7777}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h0000, 16'h0000, 16'hFFFF}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h0300, 16'hFD00, 16'h0001}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h7FFF, 16'h7FFF, 16'h0002}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h8000, 16'h8000, 16'h0003}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h0002, 16'hFFFE, 16'h0004}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h00FF, 16'hFF01, 16'h0005}, 1'b0, NO_HAND},
        '{'{FN_UP,   16'h8000, 16'h7FFF, 16'h0006}, 1'b1,
          '{3'd7, KIND_RELEASED, 16'h0006, 16'h8000, 16'h7FFF, 1'b1}},
        '{'{FN_TICK, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_HAND}
    };

    logic          clk;
    logic          rst_n     = 1'b0;
    logic          start     = 1'b0;
    cmd_t          cmd       = '0;
    logic          busy;
    logic          cfg_we    = 1'b0;
    logic [SCALE_W-1:0] cfg_wdata = SCALE_RESET;
    logic          result_valid;
    result_t       result;

    // predictor state
    logic [SCALE_W-1:0] scale_now;
    phase_t        slot_ph  [NUM_SLOTS];
    logic [ID_W-1:0]    slot_id  [NUM_SLOTS];
    logic [COORD_W-1:0] slot_xs  [NUM_SLOTS];
    logic [COORD_W-1:0] slot_ys  [NUM_SLOTS];

    result_t       frame_reports [$];
    result_t       pending_reports [$];
    logic [ID_W-1:0]    id_pool [POOL_SIZE];
    int            mismatch_cnt = 0;
    int            stall_cycles = 0;

    multitouch_slot_tracker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // q8.8 scaling, truncated toward zero, saturated to 16 bits
    function automatic logic [COORD_W-1:0] scale_coord(input logic [COORD_W-1:0] raw);
        longint unsigned mag;
        longint unsigned prod;
        mag  = raw[COORD_W-1] ? (64'd65536 - 64'(raw)) : 64'(raw);
        prod = (mag * 64'(scale_now)) >> 8;
        if (raw[COORD_W-1])
        begin
            if (prod >= 64'd32768)
                return 16'h8000;
            return 16'(64'd65536 - prod);
        end
        if (prod > 64'd32767)
            return 16'h7FFF;
        return prod[15:0];
    endfunction

    // apply one command to the slot table and collect the reports it causes
    task automatic track_event(input cmd_t c);
        int            i;
        int            hit;
        int            active;
        int            seen;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        result_t       r;
        frame_reports.delete();
        if (c.func != FN_TICK)
        begin
            sx  = scale_coord(c.x_raw);
            sy  = scale_coord(c.y_raw);
            hit = -1;
            for (i = 0; i < NUM_SLOTS; i++)
                if (hit < 0 && slot_ph[i] != PH_EMPTY && slot_id[i] == c.contact_id)
                    hit = i;
            if (hit >= 0)
            begin
                // held id: move or up takes the new position, down is ignored
                if (c.func == FN_MOVE || c.func == FN_UP)
                begin
                    slot_xs[hit] = sx;
                    slot_ys[hit] = sy;
                    slot_ph[hit] = (c.func == FN_MOVE) ? PH_MOVE : PH_UP;
                end
            end
            else if (c.func == FN_DOWN)
            begin
                // unmatched down takes the first free slot, if any
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (hit < 0 && slot_ph[i] == PH_EMPTY)
                    begin
                        hit        = i;
                        slot_ph[i] = PH_DOWN;
                        slot_id[i] = c.contact_id;
                        slot_xs[i] = sx;
                        slot_ys[i] = sy;
                    end
                end
            end
        end
        // one report per active slot, in slot order
        active = 0;
        for (i = 0; i < NUM_SLOTS; i++)
            if (slot_ph[i] != PH_EMPTY)
                active++;
        seen = 0;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_ph[i] != PH_EMPTY)
            begin
                seen++;
                r.slot_index = IDX_W'(i);
                case (slot_ph[i])
                    PH_DOWN: r.report_kind = KIND_PRESSED;
                    PH_MOVE: r.report_kind = KIND_MOVED;
                    default: r.report_kind = KIND_RELEASED;
                endcase
                r.report_id = slot_id[i];
                r.report_x  = slot_xs[i];
                r.report_y  = slot_ys[i];
                r.last      = (seen == active);
                frame_reports = {frame_reports, r};
            end
        end
        // released slots free up, pressed slots move on
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_ph[i] == PH_UP)
            begin
                slot_ph[i] = PH_EMPTY;
                slot_id[i] = '0;
                slot_xs[i] = '0;
                slot_ys[i] = '0;
            end
            else if (slot_ph[i] == PH_DOWN)
                slot_ph[i] = PH_MOVE;
        end
    endtask

    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("[%0t] %s: expected slot %0d kind %0d id %h x %h y %h last %0b,",
                     $realtime, what,
                     want.slot_index, want.report_kind, want.report_id,
                     want.report_x, want.report_y, want.last,
                     " got slot %0d kind %0d id %h x %h y %h last %0b",
                     got.slot_index, got.report_kind, got.report_id,
                     got.report_x, got.report_y, got.last);
    endtask

    // report checker
    always @(posedge clk)
    begin : report_check
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_reports.size() == 0)
                note_mismatch("report with nothing pending", '0, result);
            else
            begin
                want = pending_reports.pop_front();
                if (result.slot_index  !== want.slot_index  ||
                    result.report_kind !== want.report_kind ||
                    result.report_id   !== want.report_id   ||
                    result.report_x    !== want.report_x    ||
                    result.report_y    !== want.report_y    ||
                    result.last        !== want.last)
                    note_mismatch("report mismatch", want, result);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // drive one command and wait for its transfer
    task automatic send_touch(input cmd_t c, input logic hand_ok, input result_t hand);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        track_event(c);
        if (hand_ok)
            pending_reports = {pending_reports, hand};
        else
            foreach (frame_reports[k])
                pending_reports = {pending_reports, frame_reports[k]};
    endtask

    // random gap on the command side
    task automatic maybe_idle(input logic no_gaps);
        int n;
        if (!no_gaps && $urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // let the block drain, then write the scale register
    task automatic set_scale(input logic [SCALE_W-1:0] v);
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scale_now = v;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 600) - 300);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    3: v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // mostly well-formed contact traffic on a small id pool, some stray ids
    function automatic cmd_t rand_touch();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            c.func = FN_TICK;
        else if (pick < 45)
            c.func = FN_DOWN;
        else if (pick < 78)
            c.func = FN_MOVE;
        else
            c.func = FN_UP;
        c.x_raw = rand_coord();
        c.y_raw = rand_coord();
        if ($urandom_range(0, 99) < 85)
            c.contact_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            c.contact_id = 16'($urandom);
        return c;
    endfunction

    function automatic logic [SCALE_W-1:0] phase_scale(input int p);
        case (p)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'h0180;
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus
    initial
    begin
        int i;
        int p;
        scale_now = SCALE_RESET;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            slot_ph[i] = PH_EMPTY;
            slot_id[i] = '0;
            slot_xs[i] = '0;
            slot_ys[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk at unity scale
        set_scale(SCALE_RESET);
        foreach (TOUCH_SCRIPT[r])
        begin
            maybe_idle(1'b0);
            send_touch(TOUCH_SCRIPT[r].c, TOUCH_SCRIPT[r].hand_ok, TOUCH_SCRIPT[r].hand);
        end

        // random phases over several scale settings
        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_scale(phase_scale(p));
            id_pool[0] = 16'h0000;
            id_pool[1] = 16'hFFFF;
            for (i = 2; i < POOL_SIZE; i++)
                id_pool[i] = 16'($urandom);
            repeat (PHASE_ITEMS)
            begin
                maybe_idle(p == 2);
                send_touch(rand_touch(), 1'b0, NO_HAND);
            end
        end

        // drain
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatch_cnt == 0 && pending_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/mts_pkg.sv
rtl/mts_scaler.sv
rtl/mts_cell.sv
rtl/multitouch_slot_tracker.sv
tb/sv/tb.sv
